// ----- hw/rtl/wmf_pkg.sv -----
// wmf_pkg: shared constants, beat types and window entry type for the
// window median filter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wmf_pkg;

    // Window geometry
    localparam int WINDOW   = 5;
    localparam int CHANNELS = 4;
    localparam int MID      = WINDOW / 2;

    // Valid-entry counts that pick the output rule
    localparam int MEDIAN_MIN_VALID = 3;
    localparam int MEAN_PAIR        = 2;

    // Widths
    localparam int DIST_W = 13;
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RANK_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [RANK_W-1:0] t_rank;
    typedef logic [CNT_W-1:0]  t_cnt;

    // One window entry; ok in the MSB so invalid entries sort lowest
    typedef struct packed {
        logic  ok;
        t_dist value;
    } t_entry;

    // Input beat
    typedef struct packed {
        t_dist front_dist;
        logic  front_ok;
        t_dist down_dist;
        logic  down_ok;
        t_dist left_dist;
        logic  left_ok;
        t_dist right_dist;
        logic  right_ok;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        t_dist front_filtered;
        logic  front_filtered_ok;
        t_dist down_filtered;
        logic  down_filtered_ok;
        t_dist left_filtered;
        logic  left_filtered_ok;
        t_dist right_filtered;
        logic  right_filtered_ok;
    } t_out_beat;

endpackage

`default_nettype wire

// ----- hw/rtl/wmf_chan_ring.sv -----
// wmf_chan_ring: WINDOW-entry sample ring for one channel, valid bits
// cleared at reset, invalid entries read as zero. Uses wmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmf_chan_ring
    import wmf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire t_pos                 i_wr_pos,
    input  wire t_entry               i_wr_entry,
    output t_entry [WINDOW-1:0]       o_ring
);

    logic [WINDOW-1:0] r_ok;
    t_dist             r_dist [WINDOW];

    // Valid bits: control state, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok <= '0;
        end else if (i_wr_en) begin
            r_ok[i_wr_pos] <= i_wr_entry.ok;
        end
    end

    // Distance payload
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_dist[i_wr_pos] <= i_wr_entry.value;
        end
    end

    // Invalid entries read as value zero
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            o_ring[i].ok    = r_ok[i];
            o_ring[i].value = r_ok[i] ? r_dist[i] : '0;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wmf_chan_select.sv -----
// wmf_chan_select: rank-based order selection over one channel's window:
// middle-ranked window entry, invalid entries lowest, for three or more valid
// entries; mean or single value otherwise. Uses wmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmf_chan_select
    import wmf_pkg::*;
(
    input  wire t_entry [WINDOW-1:0] i_ring,
    output t_entry                   o_result
);

    logic [WINDOW-1:0] w_less [WINDOW];
    t_rank             w_rank [WINDOW];
    logic [WINDOW-1:0] w_ok;
    t_cnt              w_cnt;
    t_entry            w_mid;
    t_entry            w_top;
    t_entry            w_next;
    logic [DIST_W:0]   w_pair_sum;

    // Rank of each entry: entries below it, ties broken by slot index
    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW; j++) begin
                w_less[i][j] = (i_ring[j] < i_ring[i]) ||
                               ((i_ring[j] == i_ring[i]) && (j < i));
            end
            w_rank[i] = RANK_W'($countones(w_less[i]));
        end
    end

    // Pick sorted slots by rank match (ranks form a permutation)
    always_comb begin
        w_mid  = '0;
        w_top  = '0;
        w_next = '0;
        for (int i = 0; i < WINDOW; i++) begin
            w_ok[i] = i_ring[i].ok;
            if (w_rank[i] == RANK_W'(MID)) begin
                w_mid = w_mid | i_ring[i];
            end
            if (w_rank[i] == RANK_W'(WINDOW - 1)) begin
                w_top = w_top | i_ring[i];
            end
            if (w_rank[i] == RANK_W'(WINDOW - 2)) begin
                w_next = w_next | i_ring[i];
            end
        end
    end

    assign w_cnt      = CNT_W'($countones(w_ok));
    assign w_pair_sum = {1'b0, w_top.value} + {1'b0, w_next.value};

    // Output rule by valid count; an invalid middle slot reads as zero
    always_comb begin
        o_result.ok = |w_ok;
        if (w_cnt >= CNT_W'(MEDIAN_MIN_VALID)) begin
            o_result.value = w_mid.value;
        end else if (w_cnt == CNT_W'(MEAN_PAIR)) begin
            o_result.value = w_pair_sum[DIST_W:1];
        end else begin
            o_result.value = w_top.value;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/window_median_filter.sv -----
// Four-channel sliding-window median filter. Each input beat writes one
// reading per channel into that channel's five-entry ring at a shared slot;
// the result beat carries, per channel, the middle-ranked entry of the window
// with invalid entries ranked lowest (or the single value, or the truncated
// mean of two) and a flag that is low when no entry is valid. One beat is
// accepted every cycle while the output side keeps up. The ring is written at
// acceptance; the rank compare runs between the ring registers and the output
// register, which loads when the output side can take it. The input side
// accepts one more beat while a result waits at the output, then stalls.
// Rings are empty right after reset, with no clearing pass.
// Uses wmf_pkg, wmf_chan_ring and wmf_chan_select.
`timescale 1ns / 1ps
`default_nettype none

module window_median_filter
    import wmf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data
);

    t_pos      r_wr_pos;
    t_pos      n_wr_pos;
    logic      r_s1_valid;
    logic      n_s1_valid;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_beat r_out_data;

    logic      w_in_fire;
    logic      w_out_load;
    t_entry    w_in_entry [CHANNELS];
    t_entry    w_result   [CHANNELS];

    // Handshake
    assign w_out_load = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_out_load;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // Input beat to per-channel entries; invalid readings stored as zero
    always_comb begin
        w_in_entry[0].ok    = i_in_data.front_ok;
        w_in_entry[0].value = i_in_data.front_ok ? i_in_data.front_dist : '0;
        w_in_entry[1].ok    = i_in_data.down_ok;
        w_in_entry[1].value = i_in_data.down_ok ? i_in_data.down_dist : '0;
        w_in_entry[2].ok    = i_in_data.left_ok;
        w_in_entry[2].value = i_in_data.left_ok ? i_in_data.left_dist : '0;
        w_in_entry[3].ok    = i_in_data.right_ok;
        w_in_entry[3].value = i_in_data.right_ok ? i_in_data.right_dist : '0;
    end

    // Per-channel ring and selection
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        t_entry [WINDOW-1:0] w_ring;

        wmf_chan_ring u_ring (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_in_fire),
            .i_wr_pos   (r_wr_pos),
            .i_wr_entry (w_in_entry[c]),
            .o_ring     (w_ring)
        );

        wmf_chan_select u_select (
            .i_ring   (w_ring),
            .o_result (w_result[c])
        );
    end

    // Next-state logic: write slot, compute stage, output register
    always_comb begin
        n_wr_pos = r_wr_pos;
        if (w_in_fire) begin
            n_wr_pos = (r_wr_pos == POS_W'(WINDOW - 1)) ? '0 : r_wr_pos + 1'b1;
        end
        n_s1_valid = r_s1_valid;
        if (w_in_fire) begin
            n_s1_valid = 1'b1;
        end else if (w_out_load) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = w_out_load ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos    <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pos    <= n_wr_pos;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s1_valid) begin
            r_out_data.front_filtered    <= w_result[0].value;
            r_out_data.front_filtered_ok <= w_result[0].ok;
            r_out_data.down_filtered     <= w_result[1].value;
            r_out_data.down_filtered_ok  <= w_result[1].ok;
            r_out_data.left_filtered     <= w_result[2].value;
            r_out_data.left_filtered_ok  <= w_result[2].ok;
            r_out_data.right_filtered    <= w_result[3].value;
            r_out_data.right_filtered_ok <= w_result[3].ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Write slot never leaves the window
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pos < POS_W'(WINDOW))
        else $error("write slot out of range");

    // No new beat while a computed result cannot move to the output
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted over a stalled result");

    // Every accepted beat occupies the compute stage next cycle
    a_in_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_s1_valid)
        else $error("accepted beat lost");

    // A computed result reaches the output when the output can load
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_out_load) |=> o_out_valid)
        else $error("result not presented");

    // An empty front-channel window reports zero distance
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.front_filtered_ok) |->
            (o_out_data.front_filtered == '0))
        else $error("empty window with nonzero distance");

endmodule

`default_nettype wire

// ----- tb/tb_window_median_filter.sv -----
// tb_window_median_filter: self-checking bench for the four-channel window
// median filter. Directed table rows, then random reading beats, each result
// checked against a fixed value or a local ring model; uses wmf_pkg and RTL.
`timescale 1ns / 1ps

module tb_window_median_filter;
    import wmf_pkg::*;

    localparam int    RAND_BEATS   = 850;
    localparam int    CALM_BEATS   = 120;
    localparam int    LONG_HOLD    = 200;
    localparam int    CYCLE_LIMIT  = 200000;
    localparam int    DRAIN_CYCLES = 10;
    localparam t_dist DIST_MAX     = '1;
    localparam t_dist RANGE_MAX    = 6400;

    // Per-channel view of a beat: index 0..3 is front, down, left, right
    typedef t_entry [CHANNELS-1:0] t_chan_vec;

    typedef struct {
        t_in_beat  beat;
        bit        fixed;
        t_out_beat want;
    } t_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_beat  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_data;

    bit        calm      = 1'b0;
    bit        hold_req  = 1'b0;
    int        errors    = 0;
    int        cycles    = 0;

    string     chan_tag [CHANNELS] = '{"front", "down", "left", "right"};

    // Local copy of the rings and the shared write slot
    t_entry    ring [CHANNELS][WINDOW];
    int        wr_slot = 0;

    t_out_beat pending_filtered [$];

    window_median_filter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #1 clk = ~clk;

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring[c][i] = '0;
            end
        end
    end

    function automatic t_in_beat mk_in(t_dist fd, logic fo, t_dist dd, logic dok,
                                       t_dist ld, logic lo, t_dist rd, logic ro);
        return '{front_dist: fd, front_ok: fo, down_dist: dd, down_ok: dok,
                 left_dist: ld, left_ok: lo, right_dist: rd, right_ok: ro};
    endfunction

    function automatic t_chan_vec split_out(t_out_beat b);
        t_chan_vec v;
        v[0] = '{ok: b.front_filtered_ok, value: b.front_filtered};
        v[1] = '{ok: b.down_filtered_ok,  value: b.down_filtered};
        v[2] = '{ok: b.left_filtered_ok,  value: b.left_filtered};
        v[3] = '{ok: b.right_filtered_ok, value: b.right_filtered};
        return v;
    endfunction

    // Write one beat into the rings, then filter every ring
    function automatic t_out_beat filter_beat(t_in_beat b);
        t_chan_vec rd;
        t_chan_vec res;
        t_dist     vals [WINDOW];
        t_dist     v;
        int        k;
        int        j;
        int        invalid;
        rd[0] = '{ok: b.front_ok, value: b.front_dist};
        rd[1] = '{ok: b.down_ok,  value: b.down_dist};
        rd[2] = '{ok: b.left_ok,  value: b.left_dist};
        rd[3] = '{ok: b.right_ok, value: b.right_dist};
        for (int c = 0; c < CHANNELS; c++) begin
            ring[c][wr_slot] = rd[c].ok ? rd[c] : t_entry'('0);
        end
        wr_slot = (wr_slot + 1) % WINDOW;

        for (int c = 0; c < CHANNELS; c++) begin
            k = 0;
            for (int i = 0; i < WINDOW; i++) begin
                if (ring[c][i].ok) begin
                    vals[k] = ring[c][i].value;
                    k++;
                end
            end
            // ascending insertion sort of the valid values
            for (int i = 1; i < k; i++) begin
                v = vals[i];
                j = i - 1;
                while (j >= 0 && vals[j] > v) begin
                    vals[j + 1] = vals[j];
                    j--;
                end
                vals[j + 1] = v;
            end
            res[c].ok = (k != 0);
            if (k == 0) begin
                res[c].value = '0;
            end else if (k == 1) begin
                res[c].value = vals[0];
            end else if (k == MEAN_PAIR) begin
                res[c].value = t_dist'(({1'b0, vals[0]} + {1'b0, vals[1]}) >> 1);
            end else begin
                // invalid entries occupy the low sorted slots
                invalid = WINDOW - k;
                res[c].value = (MID >= invalid) ? vals[MID - invalid] : t_dist'('0);
            end
        end
        return '{front_filtered: res[0].value, front_filtered_ok: res[0].ok,
                 down_filtered:  res[1].value, down_filtered_ok:  res[1].ok,
                 left_filtered:  res[2].value, left_filtered_ok:  res[2].ok,
                 right_filtered: res[3].value, right_filtered_ok: res[3].ok};
    endfunction

    function automatic t_entry rand_reading(int ok_pct);
        t_entry e;
        case ($urandom_range(9))
            0: e.value = $urandom_range(8191, 0);
            1: begin
                case ($urandom_range(3))
                    0: e.value = '0;
                    1: e.value = RANGE_MAX;
                    2: e.value = DIST_MAX;
                    default: e.value = 1;
                endcase
            end
            // few distinct values, so ties show up in the sort
            2, 3: e.value = 100 * $urandom_range(3);
            default: e.value = $urandom_range(6400);
        endcase
        e.ok = ($urandom_range(99) < ok_pct);
        return e;
    endfunction

    // Offer one beat (entered and left at a falling edge)
    task automatic send_beat(t_row row);
        int        gap;
        t_out_beat predicted;
        gap = 0;
        if (!calm && $urandom_range(3) == 0) begin
            gap = $urandom_range(9, 1);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= row.beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = filter_beat(row.beat);
        pending_filtered.push_back(row.fixed ? row.want : predicted);
        @(negedge clk);
    endtask

    // Output-side ready: random low bursts, one long hold, none when calm
    initial begin : drive_out_ready
        int   n;
        logic level;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n        = LONG_HOLD;
                level    = 1'b0;
            end else if (!calm && $urandom_range(3) == 0) begin
                n     = $urandom_range(9, 1);
                level = 1'b0;
            end else begin
                n     = $urandom_range(12, 1);
                level = 1'b1;
            end
            out_ready <= level;
            repeat (n) @(negedge clk);
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk) begin : check_results
        t_out_beat want;
        t_chan_vec want_v;
        t_chan_vec got_v;
        if (rst_n && out_valid && out_ready) begin
            if (pending_filtered.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, got %h", $time,
                         out_data);
            end else begin
                want   = pending_filtered.pop_front();
                want_v = split_out(want);
                got_v  = split_out(out_data);
                for (int c = 0; c < CHANNELS; c++) begin
                    if (got_v[c].value !== want_v[c].value) begin
                        errors++;
                        $display("%0t: %s_filtered expected %0d, got %0d", $time,
                                 chan_tag[c], want_v[c].value, got_v[c].value);
                    end
                    if (got_v[c].ok !== want_v[c].ok) begin
                        errors++;
                        $display("%0t: %s_filtered_ok expected %0d, got %0d", $time,
                                 chan_tag[c], want_v[c].ok, got_v[c].ok);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        t_row   rows [$];
        t_row   row;
        t_entry e [CHANNELS];
        int     ok_pct;

        // Directed table; fixed rows carry results read straight off the rules
        // (t_out_beat has the same bit layout as t_in_beat)
        rows.push_back('{mk_in(DIST_MAX, 0, DIST_MAX, 0, DIST_MAX, 0, DIST_MAX, 0),
                         1'b1, t_out_beat'('0)});
        rows.push_back('{mk_in(RANGE_MAX, 1, 0, 1, DIST_MAX, 1, DIST_MAX, 0), 1'b1,
                         t_out_beat'(mk_in(RANGE_MAX, 1, 0, 1, DIST_MAX, 1, 0, 0))});
        rows.push_back('{mk_in(6399, 1, DIST_MAX, 1, DIST_MAX, 1, 5, 1), 1'b0, '0});
        rows.push_back('{mk_in(0, 1, 1, 1, 0, 0, 7, 1), 1'b0, '0});
        rows.push_back('{mk_in(3200, 1, 1, 0, 4096, 1, 7, 1), 1'b0, '0});
        rows.push_back('{mk_in(13'h1555, 1, 13'h0AAA, 1, 1, 1, 7, 1), 1'b0, '0});
        // slot wraps: oldest entries overwritten
        rows.push_back('{mk_in(13'h0AAA, 1, 13'h1555, 0, 0, 1, DIST_MAX, 1), 1'b0, '0});
        // drain every ring back to empty
        for (int i = 0; i < WINDOW - 1; i++) begin
            rows.push_back('{mk_in(DIST_MAX, 0, 13'h1555, 0, 13'h0AAA, 0, 1, 0),
                             1'b0, '0});
        end
        rows.push_back('{mk_in(DIST_MAX, 0, DIST_MAX, 0, DIST_MAX, 0, DIST_MAX, 0),
                         1'b1, t_out_beat'('0)});
        // valid zero, then ties
        rows.push_back('{mk_in(0, 1, 0, 0, 100, 1, 1, 1), 1'b0, '0});
        rows.push_back('{mk_in(100, 1, 100, 1, 100, 1, 1, 1), 1'b0, '0});
        rows.push_back('{mk_in(100, 1, 100, 1, 100, 1, 0, 1), 1'b0, '0});
        rows.push_back('{mk_in(100, 1, 200, 1, 50, 1, DIST_MAX, 1), 1'b0, '0});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_beat(rows[i]);
        end

        // Random beats; the first ones run into a long output stall
        hold_req = 1'b1;
        ok_pct   = 80;
        for (int n = 0; n < RAND_BEATS; n++) begin
            if (n % 50 == 0) begin
                ok_pct = ($urandom_range(3) == 0) ? $urandom_range(40, 0)
                                                  : $urandom_range(100, 60);
            end
            if (n >= RAND_BEATS - CALM_BEATS) begin
                calm = 1'b1;
            end
            for (int c = 0; c < CHANNELS; c++) begin
                e[c] = rand_reading(ok_pct);
            end
            row.beat  = mk_in(e[0].value, e[0].ok, e[1].value, e[1].ok,
                              e[2].value, e[2].ok, e[3].value, e[3].ok);
            row.fixed = 1'b0;
            row.want  = '0;
            send_beat(row);
        end
        in_valid <= 1'b0;

        while (pending_filtered.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
